>>> design/lmrs_pkg.sv
// Shared types, constants and helpers for the LED matrix row scan driver.
// No dependencies; imported by lmrs_serializer and the top module.
`default_nettype none

package lmrs_pkg;

    localparam int ROW_COUNT  = 25;
    localparam int HALF_WIDTH = 25;
    localparam int ROW_AW     = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int WORD_W     = 64;
    localparam int HALF_W     = 32;
    localparam int DIGIT_W    = 4;
    localparam int DIGITS     = HALF_W / DIGIT_W;
    localparam int CNT_W      = $clog2(DIGITS + 1);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_SCAN  = 2'd2
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WRITE = 4'b0010,
        S_SCAN  = 4'b0100,
        S_SER   = 4'b1000
    } t_state;

    typedef struct packed {
        logic       load;
        logic [7:0] code;
    } t_ser_ctl;

    typedef struct packed {
        logic busy;
    } t_ser_sts;

    function automatic logic [7:0] row_code(input logic [ROW_AW-1:0] row);
        logic [7:0] n;
        logic [7:0] t;
        n = 8'(row) + 8'd1;
        t = n - 8'd15;
        if (n < 8'd16) begin
            return n;
        end
        return {t[3:0], 4'b0000};
    endfunction

endpackage

`default_nettype wire

>>> design/lmrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module lmrs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 25
) (
    input  wire                                      i_clk,
    input  wire                                      i_wr_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]                         i_wr_data,
    input  wire                                      i_rd_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/lmrs_serializer.sv
// Digit-serial output stage: shifts one row word into the two half-word
// output registers a digit per cycle, then presents the lit and blanking results.
// Depends on lmrs_pkg.
`default_nettype none

module lmrs_serializer (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire  lmrs_pkg::t_ser_ctl    i_ctl,
    input  wire  [lmrs_pkg::WORD_W-1:0] i_data,
    output lmrs_pkg::t_ser_sts          o_sts,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [lmrs_pkg::HALF_W-1:0] o_right_bits,
    output logic [lmrs_pkg::HALF_W-1:0] o_left_bits,
    output logic [7:0]                  o_row_select,
    output logic                        o_lit,
    output logic                        o_last
);

    import lmrs_pkg::*;

    logic [WORD_W-1:0] r_src;
    logic [HALF_W-1:0] r_right;
    logic [HALF_W-1:0] r_left;
    logic [7:0]        r_code;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_shift;
    logic              r_out_valid;
    logic              r_lit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= 1'b0;
            r_out_valid <= 1'b0;
            r_lit       <= 1'b0;
            r_cnt       <= '0;
        end else if (i_ctl.load) begin
            r_src   <= i_data;
            r_code  <= i_ctl.code;
            r_cnt   <= CNT_W'(DIGITS);
            r_shift <= 1'b1;
        end else if (r_shift) begin
            r_right <= {r_right[HALF_W-DIGIT_W-1:0], r_src[WORD_W-1 -: DIGIT_W]};
            r_left  <= {r_left[HALF_W-DIGIT_W-1:0], r_src[HALF_W-1 -: DIGIT_W]};
            r_src   <= r_src << DIGIT_W;
            r_cnt   <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_shift     <= 1'b0;
                r_out_valid <= 1'b1;
                r_lit       <= 1'b1;
            end
        end else if (r_out_valid && !i_stall) begin
            if (r_lit) begin
                r_lit   <= 1'b0;
                r_right <= '0;
                r_left  <= '0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.busy   = r_shift | r_out_valid;
    assign o_valid      = r_out_valid;
    assign o_right_bits = r_right;
    assign o_left_bits  = r_left;
    assign o_row_select = r_code;
    assign o_lit        = r_lit;
    assign o_last       = ~r_lit;

    a_blank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_lit) |-> (o_right_bits == '0 && o_left_bits == '0))
        else $error("blanking result carries data");

    a_blank_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_lit && !i_stall) |=> (o_valid && !o_lit && $stable(o_row_select)))
        else $error("lit result not followed by blanking result");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.load |-> !o_sts.busy)
        else $error("load while busy");

endmodule

`default_nettype wire

>>> design/led_matrix_row_scan_driver_top.sv
// LED matrix row scan driver: command decode, frame store and scan control.
// Depends on lmrs_pkg, lmrs_ram and lmrs_serializer.
//
// Input channel (i_valid / o_stall) takes one command per transaction:
// write pixel, clear frame or scan the next row. Output channel
// (o_valid / i_stall) gives two transactions per scan: the lit latch with
// the row's right and left half words and its row-select code, then the
// blanking latch with zero data, the same code and o_last set.
// A pixel write reads and rewrites one store row. A clear works through
// per-row valid bits and leaves the input ready for the next command. A
// scan reads the row, then the serializer shifts 4 bits per half per
// cycle before the lit result appears; the next command is taken once
// both results have been delivered.
// Reset (synchronous, active low) empties the store and returns the scan
// to the first row. While the receiver stalls, the pending result holds and
// o_stall stays high.
`default_nettype none

module led_matrix_row_scan_driver_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [1:0]  i_cmd,
    input  wire  [5:0]  i_column,
    input  wire  [4:0]  i_row_index,
    input  wire         i_pixel_on,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [31:0] o_right_bits,
    output logic [31:0] o_left_bits,
    output logic [7:0]  o_row_select,
    output logic        o_lit,
    output logic        o_last
);

    import lmrs_pkg::*;

    t_state             r_state;
    t_state             n_state;
    logic [ROW_AW-1:0]  r_scan_row;
    logic [ROW_AW-1:0]  n_scan_row;
    logic [ROW_COUNT-1:0] r_valid;
    logic [ROW_AW-1:0]  r_row;
    logic [5:0]         r_pos;
    logic               r_on;
    logic [7:0]         r_code;

    logic               accept;
    logic               in_range;
    logic [5:0]         pos;
    logic [ROW_AW-1:0]  rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic [WORD_W-1:0]  base;
    logic [WORD_W-1:0]  mask;
    logic [WORD_W-1:0]  wr_data;
    logic               wr_en;
    t_ser_ctl           ser_ctl;
    t_ser_sts           ser_sts;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign in_range = (i_row_index < 5'(ROW_COUNT)) &&
                      ({1'b0, i_column} < 7'(2 * HALF_WIDTH));
    assign pos      = (i_column < 6'(HALF_WIDTH)) ? i_column
                                                  : i_column + 6'(32 - HALF_WIDTH);
    assign rd_addr  = (i_cmd == CMD_SCAN) ? r_scan_row : i_row_index[ROW_AW-1:0];

    assign base    = r_valid[r_row] ? rd_data : '0;
    assign mask    = WORD_W'(1) << r_pos;
    assign wr_data = r_on ? (base | mask) : (base & ~mask);
    assign wr_en   = (r_state == S_WRITE);

    assign ser_ctl.load = (r_state == S_SCAN);
    assign ser_ctl.code = r_code;

    always_comb begin
        n_state    = r_state;
        n_scan_row = r_scan_row;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_cmd'(i_cmd))
                        CMD_WRITE: begin
                            if (in_range) begin
                                n_state = S_WRITE;
                            end
                        end
                        CMD_SCAN: begin
                            n_state = S_SCAN;
                            if (r_scan_row == ROW_AW'(ROW_COUNT - 1)) begin
                                n_scan_row = '0;
                            end else begin
                                n_scan_row = r_scan_row + ROW_AW'(1);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WRITE: n_state = S_IDLE;
            S_SCAN:  n_state = S_SER;
            S_SER: begin
                if (!ser_sts.busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_scan_row <= '0;
            r_valid    <= '0;
        end else begin
            r_state    <= n_state;
            r_scan_row <= n_scan_row;
            if (accept && i_cmd == CMD_CLEAR) begin
                r_valid <= '0;
            end else if (wr_en) begin
                r_valid[r_row] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_row  <= rd_addr;
            r_pos  <= pos;
            r_on   <= i_pixel_on;
            r_code <= row_code(r_scan_row);
        end
    end

    lmrs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROW_COUNT)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_row),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lmrs_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ser_ctl),
        .i_data       (base),
        .o_sts        (ser_sts),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_right_bits (o_right_bits),
        .o_left_bits  (o_left_bits),
        .o_row_select (o_row_select),
        .o_lit        (o_lit),
        .o_last       (o_last)
    );

    a_scan_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_row < ROW_AW'(ROW_COUNT))
        else $error("scan row out of range");

    a_write_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_row < ROW_AW'(ROW_COUNT)))
        else $error("store write outside frame");

    a_output_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_SER))
        else $error("result outside scan");

endmodule

`default_nettype wire
